FILE: rtl/sem_pkg.sv
// Shared widths, finalize step codes and controller/datapath bundles.
`default_nettype none

package sem_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int CNT_W       = 15;
  localparam int MAX_SAMPLES = 16384;
  localparam int ERR_W       = SAMPLE_W + 1;
  localparam int SQE_W       = 63;
  localparam int ABS_W       = 39;
  localparam int SUM_W       = 38;
  localparam int SQ_W        = 61;
  localparam int CROSS_W     = 62;

  localparam int MUL_W       = 76;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int DIFF_W      = MUL_W + 1;
  localparam int DIV_W       = 182;
  localparam int QUO_W       = SQE_W;
  localparam int STEP_W      = $clog2(QUO_W + 1);
  localparam int ROOT_IN_W   = 64;
  localparam int ROOT_OUT_W  = 32;
  localparam int ROOT_STEPS  = 32;

  localparam int MSE_W       = 49;
  localparam int RMS_W       = 25;
  localparam int MAE_W       = 24;
  localparam int CORR_W      = 16;
  localparam int CORR_FRAC   = 15;
  localparam int CQ_W        = 2 * CORR_FRAC + 1;

  localparam int MSE_SHIFT   = SQE_W - 1;
  localparam int MAE_SHIFT   = ABS_W - 1;
  localparam int CORR_SHIFT  = 2 * CORR_FRAC;

  // Finalize steps, run in this order.
  typedef enum logic [3:0] {
    OP_MSE,
    OP_MAE,
    OP_RMS,
    OP_NXX,
    OP_XX,
    OP_NYY,
    OP_YY,
    OP_NXY,
    OP_XY,
    OP_NUM2,
    OP_DEN,
    OP_CDIV,
    OP_CROOT
  } op_t;

  typedef struct packed {
    logic load;
    logic square;
    logic accum;
    logic op_start;
    logic op_store;
    logic publish;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic op_done;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/sem_ifs.sv
// Valid/ready channel interfaces for sample pairs and metric results.
`default_nettype none

interface sem_in_if import sem_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] real_value;
  logic signed [SAMPLE_W-1:0] sim_value;
  logic                       last;

  modport source(output valid, real_value, sim_value, last, input ready);
  modport sink(input valid, real_value, sim_value, last, output ready);
endinterface

interface sem_out_if import sem_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CNT_W-1:0]         sample_count;
  logic [MSE_W-1:0]         mean_sq_error;
  logic [RMS_W-1:0]         rms_error;
  logic [SAMPLE_W-1:0]      peak_abs_error;
  logic [MAE_W-1:0]         mean_abs_error;
  logic signed [CORR_W-1:0] correlation;
  logic                     overflow;

  modport source(output valid, sample_count, mean_sq_error, rms_error, peak_abs_error,
                 mean_abs_error, correlation, overflow, input ready);
  modport sink(input valid, sample_count, mean_sq_error, rms_error, peak_abs_error,
               mean_abs_error, correlation, overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/signal_error_metrics.sv
// Error and correlation metrics over a series of measured/simulated sample pairs.
//
// Channels: in_ch carries one item per sample pair (real_value, sim_value, last);
// out_ch carries one result item per series, produced by the item with last set.
// Each accepted item is latched, squared and accumulated in turn; ready is high
// only while the block waits for the next pair.
// After the last item the finalize sequence runs on three shared iterative units:
// a shift-add multiplier (8 products), a restoring divider (three quotients)
// and a square-root unit (used twice). Each step passes through a start state and
// a wait state in the controller; the series accumulators clear as the result
// is loaded.
// The result sits in an output register: new pairs are accepted while it waits,
// and only the next series' publish holds if the receiver is still stalling.
// Pairs past 16384 in one series are dropped and flag overflow.
// Reset (rst_n low, synchronous) clears the accumulators and drops any pending
// result; no clearing pass is needed.
`default_nettype none

module signal_error_metrics import sem_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  sem_in_if.sink   in_ch,
  sem_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence intake and finalize steps.
  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the sums, run the arithmetic, hold the result.
  sem_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_real_value      (in_ch.real_value),
    .in_sim_value       (in_ch.sim_value),
    .in_last            (in_ch.last),
    .out_sample_count   (out_ch.sample_count),
    .out_mean_sq_error  (out_ch.mean_sq_error),
    .out_rms_error      (out_ch.rms_error),
    .out_peak_abs_error (out_ch.peak_abs_error),
    .out_mean_abs_error (out_ch.mean_abs_error),
    .out_correlation    (out_ch.correlation),
    .out_overflow       (out_ch.overflow)
  );

endmodule

`default_nettype wire

FILE: rtl/sem_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none

module sem_mul import sem_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] prod,
  output logic              done
);

  localparam int CW = $clog2(MUL_W + 1);

  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] a_sh_r;
  logic [MUL_W-1:0]  b_sh_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MUL_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= '0;
      a_sh_r <= PROD_W'(a);
      b_sh_r <= b;
    end else if (busy_r) begin
      if (b_sh_r[0]) begin
        acc_r <= acc_r + a_sh_r;
      end
      a_sh_r <= a_sh_r << 1;
      b_sh_r <= b_sh_r >> 1;
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

`default_nettype wire

FILE: rtl/sem_div.sv
// Restoring divider with a pre-shifted divisor, one quotient bit per cycle.
`default_nettype none

module sem_div import sem_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DIV_W-1:0]  divisor,
  input  logic [STEP_W-1:0] steps,
  output logic [QUO_W-1:0]  quo,
  output logic              done
);

  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dsh_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;

  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == STEP_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[QUO_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

`default_nettype wire

FILE: rtl/sem_sqrt.sv
// Integer square root, two radicand bits per cycle.
`default_nettype none

module sem_sqrt import sem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ROOT_IN_W-1:0]  radicand,
  output logic [ROOT_OUT_W-1:0] root,
  output logic                  done
);

  localparam int CW = $clog2(ROOT_STEPS + 1);

  logic [ROOT_IN_W-1:0] v_r;
  logic [ROOT_IN_W-1:0] root_r;
  logic [ROOT_IN_W-1:0] pow_r;
  logic [ROOT_IN_W-1:0] trial;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;

  assign trial = root_r + pow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ROOT_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      root_r <= '0;
      pow_r  <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r    <= v_r - trial;
        root_r <= (root_r >> 1) + pow_r;
      end else begin
        root_r <= root_r >> 1;
      end
      pow_r <= pow_r >> 2;
    end
  end

  assign root = root_r[ROOT_OUT_W-1:0];
  assign done = done_r;

endmodule

`default_nettype wire

FILE: rtl/sem_dp.sv
// Datapath: per-pair accumulators, finalize registers and result holding registers.
`default_nettype none

module sem_dp import sem_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic signed [SAMPLE_W-1:0] in_real_value,
  input  logic signed [SAMPLE_W-1:0] in_sim_value,
  input  logic                       in_last,
  output logic [CNT_W-1:0]           out_sample_count,
  output logic [MSE_W-1:0]           out_mean_sq_error,
  output logic [RMS_W-1:0]           out_rms_error,
  output logic [SAMPLE_W-1:0]        out_peak_abs_error,
  output logic [MAE_W-1:0]           out_mean_abs_error,
  output logic signed [CORR_W-1:0]   out_correlation,
  output logic                       out_overflow
);

  // Latched pair and per-pair products.
  logic signed [SAMPLE_W-1:0]   r_r, s_r;
  logic [ERR_W-1:0]             ae_r;
  logic                         last_r;
  logic [2*ERR_W-1:0]           sqe_p_r;
  logic signed [2*SAMPLE_W-1:0] rsq_p_r, ssq_p_r, cross_p_r;
  logic signed [ERR_W-1:0]      diff;

  // Series accumulators.
  logic [CNT_W-1:0]          pair_count_r;
  logic [SQE_W-1:0]          sum_sq_err_r;
  logic [ABS_W-1:0]          sum_abs_err_r;
  logic [SAMPLE_W-1:0]       peak_err_r;
  logic signed [SUM_W-1:0]   sum_real_r, sum_sim_r;
  logic [SQ_W-1:0]           sum_real_sq_r, sum_sim_sq_r;
  logic signed [CROSS_W-1:0] sum_cross_r;
  logic                      ovf_r;

  // Finalize results.
  logic [QUO_W-1:0]         mse_r;
  logic [MAE_W-1:0]         mae_r;
  logic [RMS_W-1:0]         rms_r;
  logic signed [DIFF_W-1:0] part_r, da2_r, db2_r, num_r;
  logic [PROD_W-1:0]        num2_r, den_r;
  logic [CQ_W-1:0]          cq_r;
  logic signed [CORR_W-1:0] corr_r;

  logic [CNT_W-1:0]   nz;
  logic [SUM_W-1:0]   mag_x, mag_y;
  logic [CROSS_W-1:0] mag_xy;
  logic [DIFF_W-1:0]  mag_num;
  logic [DIFF_W-1:0]  prod_lo;

  logic                  mul_sel, div_sel, root_sel;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0]     mul_p;
  logic                  mul_done;
  logic [DIV_W-1:0]      div_n, div_d;
  logic [STEP_W-1:0]     div_steps;
  logic [QUO_W-1:0]      div_q;
  logic                  div_done;
  logic [ROOT_IN_W-1:0]  root_in;
  logic [ROOT_OUT_W-1:0] root_q;
  logic                  root_done;

  logic                     degenerate;
  logic [CORR_W-1:0]        lo;
  logic signed [CORR_W-1:0] corr_val;

  assign diff    = ERR_W'(in_real_value) - ERR_W'(in_sim_value);
  assign nz      = (pair_count_r == '0) ? CNT_W'(1) : pair_count_r;
  assign mag_x   = sum_real_r[SUM_W-1] ? SUM_W'(-sum_real_r) : SUM_W'(sum_real_r);
  assign mag_y   = sum_sim_r[SUM_W-1] ? SUM_W'(-sum_sim_r) : SUM_W'(sum_sim_r);
  assign mag_xy  = sum_cross_r[CROSS_W-1] ? CROSS_W'(-sum_cross_r) : CROSS_W'(sum_cross_r);
  assign mag_num = num_r[DIFF_W-1] ? DIFF_W'(-num_r) : DIFF_W'(num_r);
  assign prod_lo = mul_p[DIFF_W-1:0];

  // Pair intake, product and accumulate steps, and series clear on publish.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_r    <= in_real_value;
      s_r    <= in_sim_value;
      last_r <= in_last;
      ae_r   <= diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
    end
    if (cmd.square) begin
      sqe_p_r   <= ae_r * ae_r;
      rsq_p_r   <= r_r * r_r;
      ssq_p_r   <= s_r * s_r;
      cross_p_r <= r_r * s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.publish) begin
      pair_count_r  <= '0;
      sum_sq_err_r  <= '0;
      sum_abs_err_r <= '0;
      peak_err_r    <= '0;
      sum_real_r    <= '0;
      sum_sim_r     <= '0;
      sum_real_sq_r <= '0;
      sum_sim_sq_r  <= '0;
      sum_cross_r   <= '0;
      ovf_r         <= 1'b0;
    end else if (cmd.accum) begin
      if (pair_count_r == CNT_W'(MAX_SAMPLES)) begin
        ovf_r <= 1'b1;
      end else begin
        pair_count_r  <= pair_count_r + CNT_W'(1);
        sum_sq_err_r  <= sum_sq_err_r + SQE_W'(sqe_p_r);
        sum_abs_err_r <= sum_abs_err_r + ABS_W'(ae_r);
        if (ERR_W'(peak_err_r) < ae_r) begin
          peak_err_r <= ae_r[SAMPLE_W-1:0];
        end
        sum_real_r    <= sum_real_r + SUM_W'(r_r);
        sum_sim_r     <= sum_sim_r + SUM_W'(s_r);
        sum_real_sq_r <= sum_real_sq_r + SQ_W'(rsq_p_r);
        sum_sim_sq_r  <= sum_sim_sq_r + SQ_W'(ssq_p_r);
        sum_cross_r   <= sum_cross_r + CROSS_W'(cross_p_r);
      end
    end
  end

  // Route each finalize step to its unit.
  always_comb begin
    mul_sel  = 1'b0;
    div_sel  = 1'b0;
    root_sel = 1'b0;
    unique case (cmd.op)
      OP_MSE, OP_MAE, OP_CDIV: div_sel = 1'b1;
      OP_RMS, OP_CROOT:        root_sel = 1'b1;
      OP_NXX, OP_XX, OP_NYY, OP_YY, OP_NXY, OP_XY, OP_NUM2, OP_DEN: mul_sel = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_n     = '0;
    div_d     = '0;
    div_steps = '0;
    root_in   = '0;
    unique case (cmd.op)
      OP_MSE: begin
        div_n     = DIV_W'(sum_sq_err_r);
        div_d     = DIV_W'(nz) << MSE_SHIFT;
        div_steps = STEP_W'(MSE_SHIFT + 1);
      end
      OP_MAE: begin
        div_n     = DIV_W'(sum_abs_err_r);
        div_d     = DIV_W'(nz) << MAE_SHIFT;
        div_steps = STEP_W'(MAE_SHIFT + 1);
      end
      OP_RMS: root_in = ROOT_IN_W'(mse_r);
      OP_NXX: begin
        mul_a = MUL_W'(pair_count_r);
        mul_b = MUL_W'(sum_real_sq_r);
      end
      OP_XX: begin
        mul_a = MUL_W'(mag_x);
        mul_b = MUL_W'(mag_x);
      end
      OP_NYY: begin
        mul_a = MUL_W'(pair_count_r);
        mul_b = MUL_W'(sum_sim_sq_r);
      end
      OP_YY: begin
        mul_a = MUL_W'(mag_y);
        mul_b = MUL_W'(mag_y);
      end
      OP_NXY: begin
        mul_a = MUL_W'(pair_count_r);
        mul_b = MUL_W'(mag_xy);
      end
      OP_XY: begin
        mul_a = MUL_W'(mag_x);
        mul_b = MUL_W'(mag_y);
      end
      OP_NUM2: begin
        mul_a = mag_num[MUL_W-1:0];
        mul_b = mag_num[MUL_W-1:0];
      end
      OP_DEN: begin
        mul_a = da2_r[MUL_W-1:0];
        mul_b = db2_r[MUL_W-1:0];
      end
      OP_CDIV: begin
        div_n     = DIV_W'(num2_r) << CORR_SHIFT;
        div_d     = DIV_W'(den_r) << CORR_SHIFT;
        div_steps = STEP_W'(CORR_SHIFT + 1);
      end
      OP_CROOT: root_in = ROOT_IN_W'(cq_r);
      default: ;
    endcase
  end

  sem_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op_start && mul_sel),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_p),
    .done  (mul_done)
  );

  sem_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op_start && div_sel),
    .dividend (div_n),
    .divisor  (div_d),
    .steps    (div_steps),
    .quo      (div_q),
    .done     (div_done)
  );

  sem_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op_start && root_sel),
    .radicand (root_in),
    .root     (root_q),
    .done     (root_done)
  );

  // Correlation: zero when degenerate, +1.0 clipped, -1.0 kept.
  assign degenerate = (pair_count_r < CNT_W'(2))
                   || da2_r[DIFF_W-1] || (da2_r == '0)
                   || db2_r[DIFF_W-1] || (db2_r == '0);
  assign lo = (root_q > ROOT_OUT_W'(1 << CORR_FRAC)) ? CORR_W'(1 << CORR_FRAC)
                                                     : root_q[CORR_W-1:0];

  always_comb begin
    priority if (degenerate) begin
      corr_val = '0;
    end else if (num_r[DIFF_W-1]) begin
      corr_val = CORR_W'(-lo);
    end else if (lo > CORR_W'((1 << CORR_FRAC) - 1)) begin
      corr_val = CORR_W'((1 << CORR_FRAC) - 1);
    end else begin
      corr_val = lo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_store) begin
      unique case (cmd.op)
        OP_MSE:  mse_r <= div_q;
        OP_MAE:  mae_r <= div_q[MAE_W-1:0];
        OP_RMS:  rms_r <= root_q[RMS_W-1:0];
        OP_NXX:  part_r <= prod_lo;
        OP_XX:   da2_r <= part_r - prod_lo;
        OP_NYY:  part_r <= prod_lo;
        OP_YY:   db2_r <= part_r - prod_lo;
        OP_NXY:  part_r <= sum_cross_r[CROSS_W-1] ? -prod_lo : prod_lo;
        OP_XY:   num_r <= part_r - ((sum_real_r[SUM_W-1] ^ sum_sim_r[SUM_W-1]) ? -prod_lo
                                                                                : prod_lo);
        OP_NUM2: num2_r <= mul_p;
        OP_DEN:  den_r <= mul_p;
        OP_CDIV: cq_r <= div_q[CQ_W-1:0];
        OP_CROOT: corr_r <= corr_val;
        default: ;
      endcase
    end
  end

  // Result holding registers, loaded as the series clears.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_sample_count   <= pair_count_r;
      out_mean_sq_error  <= mse_r[MSE_W-1:0];
      out_rms_error      <= rms_r;
      out_peak_abs_error <= peak_err_r;
      out_mean_abs_error <= mae_r;
      out_correlation    <= corr_r;
      out_overflow       <= ovf_r;
    end
  end

  assign stat.last    = last_r;
  assign stat.op_done = mul_done || div_done || root_done;

endmodule

`default_nettype wire

FILE: rtl/sem_ctrl.sv
// Controller: pair intake sequencing, finalize step sequencing and output valid.
`default_nettype none

module sem_ctrl import sem_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_START,
    S_WAIT,
    S_OUT
  } state_t;

  state_t state_r;
  op_t    op_r;
  logic   out_valid_r;

  always_comb begin
    cmd    = '0;
    cmd.op = op_r;
    unique case (state_r)
      S_IDLE:   cmd.load = in_valid;
      S_SQUARE: cmd.square = 1'b1;
      S_ACCUM:  cmd.accum = 1'b1;
      S_START:  cmd.op_start = 1'b1;
      S_WAIT:   cmd.op_store = stat.op_done;
      S_OUT:    cmd.publish = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_MSE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_SQUARE;
          end
        end
        S_SQUARE: state_r <= S_ACCUM;
        S_ACCUM: begin
          if (stat.last) begin
            op_r    <= OP_MSE;
            state_r <= S_START;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_START: state_r <= S_WAIT;
        S_WAIT: begin
          if (stat.op_done) begin
            if (op_r == OP_CROOT) begin
              state_r <= S_OUT;
            end else begin
              op_r    <= op_t'(op_r + 4'd1);
              state_r <= S_START;
            end
          end
        end
        S_OUT: begin
          if (cmd.publish) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
